>>> rtl/trbr_pkg.sv
`default_nettype none
package trbr_pkg;

    localparam int RingSlots = 256;
    localparam int IdxW      = $clog2(RingSlots);
    localparam int LinkKind  = 6;
    localparam int PosW      = 12;

    localparam int TrbW      = 128;
    localparam int SDataW    = 128;
    localparam int MDataW    = 208;
    localparam int ApbAddrW  = 4;
    localparam int ApbDataW  = 64;

    localparam logic [IdxW-1:0] LinkSlot = IdxW'(RingSlots - 1);
    localparam logic [IdxW-1:0] WrapSlot = IdxW'(RingSlots - 2);

    localparam logic OpEnqueue = 1'b0;
    localparam logic OpDequeue = 1'b1;

    localparam logic RegRingBase = 1'b0;

    typedef struct packed {
        logic            en;
        logic [IdxW-1:0] addr;
        logic [TrbW-1:0] data;
    } trbr_wr_t;

    typedef struct packed {
        logic            en;
        logic [IdxW-1:0] addr;
    } trbr_rd_t;

    // control word: upper[31:16] kind[15:10] flags[9:1] cycle[0]
    function automatic logic [31:0] pack_control(input logic cyc, input logic [8:0] flags,
                                                 input logic [5:0] kind,
                                                 input logic [15:0] upper);
        pack_control = {upper, kind, flags, cyc};
    endfunction

endpackage
`default_nettype wire

>>> rtl/trbr_store.sv
`default_nettype none
module trbr_store (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire trbr_pkg::trbr_wr_t       wr,
    input  wire trbr_pkg::trbr_rd_t       rd,
    output logic [trbr_pkg::TrbW-1:0]     rd_data
);
    import trbr_pkg::*;

    logic [TrbW-1:0]      mem [RingSlots];
    logic [RingSlots-1:0] vld_reg;
    logic [TrbW-1:0]      rd_data_reg;
    logic                 rd_vld_reg;

    // entries never written read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr.en) begin
            vld_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_data_reg <= mem[rd.addr];
            rd_vld_reg  <= vld_reg[rd.addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule
`default_nettype wire

>>> rtl/trb_ring_cycle_engine_top.sv
`default_nettype none
// channel   dir  handshake                 payload
// s_        in   s_tvalid/s_tready         s_tdata block fields, s_tuser operation
// m_        out  m_tvalid/m_tready         m_tdata entry and ring state, m_tuser entry_valid
// apb       in   psel/penable, pready=1    ring_base_address at 0x0
//
// Enqueue: S_IDLE then S_DONE, via S_LINK when the producer wraps (extra store write for the link).
// Dequeue: registered store read, ownership check in S_READ, output load in S_DONE.
// One item in flight; the next is taken once its result is loaded into the output register.
// Reset: synchronous; store entries read as zero until written, no clearing pass.
// A stalled m_ side holds the block in its final state with s_tready low.
module trb_ring_cycle_engine_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // parameter[63:0] status[95:64] kind[101:96] flags[110:102] upper_control[126:111]
    input  wire logic [trbr_pkg::SDataW-1:0]     s_tdata,
    // operation[0]
    input  wire logic [0:0]                      s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // out_parameter[63:0] out_status[95:64] out_kind[101:96] out_flags[110:102]
    // out_upper_control[126:111] consumer_address[190:127] producer_position[202:191]
    // producer_cycle_out[203]
    output logic [trbr_pkg::MDataW-1:0]          m_tdata,
    // entry_valid[0]
    output logic [0:0]                           m_tuser,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [trbr_pkg::ApbAddrW-1:0]   paddr,
    input  wire logic [trbr_pkg::ApbDataW-1:0]   pwdata,
    output logic [trbr_pkg::ApbDataW-1:0]        prdata,
    output logic                                 pready
);
    import trbr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LINK = 4'b0010,
        S_READ = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [IdxW-1:0]   prod_idx_reg, prod_idx_next;
    logic              prod_cyc_reg, prod_cyc_next;
    logic [IdxW-1:0]   cons_idx_reg, cons_idx_next;
    logic              cons_cyc_reg, cons_cyc_next;
    logic [63:0]       base_reg;
    logic              res_valid_reg, res_valid_next;
    logic [TrbW-1:0]   res_entry_reg, res_entry_next;
    logic              m_tvalid_reg;
    logic [MDataW-1:0] m_tdata_reg;
    logic              m_tuser_reg;

    trbr_wr_t          wr;
    trbr_rd_t          rd;
    logic [TrbW-1:0]   rd_data;

    logic              s_acc, out_free, owned;
    logic [5:0]        rd_kind;
    logic [63:0]       cons_addr;

    trbr_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    assign pready = 1'b1;
    assign prdata = (paddr[3] == RegRingBase) ? base_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
        end else if (psel && penable && pwrite && paddr[3] == RegRingBase) begin
            base_reg <= pwdata;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign rd_kind  = rd_data[111:106];
    assign owned    = (rd_kind != 6'd0) && (rd_data[96] == cons_cyc_reg);

    always_comb begin
        wr.en   = 1'b0;
        wr.addr = prod_idx_reg;
        wr.data = {pack_control(prod_cyc_reg, s_tdata[110:102], s_tdata[101:96],
                                s_tdata[126:111]),
                   s_tdata[95:64], s_tdata[63:0]};
        rd.en   = 1'b0;
        rd.addr = cons_idx_reg;

        state_next     = state_reg;
        prod_idx_next  = prod_idx_reg;
        prod_cyc_next  = prod_cyc_reg;
        cons_idx_next  = cons_idx_reg;
        cons_cyc_next  = cons_cyc_reg;
        res_valid_next = res_valid_reg;
        res_entry_next = res_entry_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    res_valid_next = 1'b0;
                    res_entry_next = '0;
                    if (s_tuser[0] == OpEnqueue) begin
                        wr.en = 1'b1;
                        if (prod_idx_reg == WrapSlot) begin
                            state_next = S_LINK;
                        end else begin
                            prod_idx_next = prod_idx_reg + 1'b1;
                            state_next    = S_DONE;
                        end
                    end else begin
                        rd.en      = 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            S_LINK: begin
                wr.en         = 1'b1;
                wr.addr       = LinkSlot;
                wr.data       = {pack_control(prod_cyc_reg, 9'd1, 6'(LinkKind), 16'd0),
                                 32'd0, base_reg};
                prod_idx_next = '0;
                prod_cyc_next = !prod_cyc_reg;
                state_next    = S_DONE;
            end
            S_READ: begin
                if (owned) begin
                    res_valid_next = 1'b1;
                    res_entry_next = rd_data;
                    if (cons_idx_reg == LinkSlot) begin
                        cons_idx_next = '0;
                        cons_cyc_next = !cons_cyc_reg;
                    end else begin
                        cons_idx_next = cons_idx_reg + 1'b1;
                    end
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            prod_idx_reg <= '0;
            prod_cyc_reg <= 1'b1;
            cons_idx_reg <= '0;
            cons_cyc_reg <= 1'b1;
        end else begin
            state_reg    <= state_next;
            prod_idx_reg <= prod_idx_next;
            prod_cyc_reg <= prod_cyc_next;
            cons_idx_reg <= cons_idx_next;
            cons_cyc_reg <= cons_cyc_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_valid_reg <= res_valid_next;
        res_entry_reg <= res_entry_next;
    end

    assign cons_addr = base_reg + {(64 - IdxW - 4)'(0), cons_idx_reg, 4'd0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == S_DONE && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_DONE && out_free) begin
            m_tuser_reg <= res_valid_reg;
            m_tdata_reg <= {4'd0, prod_cyc_reg, PosW'(prod_idx_reg), cons_addr,
                            res_entry_reg[127:112], res_entry_reg[105:97],
                            res_entry_reg[111:106], res_entry_reg[95:64],
                            res_entry_reg[63:0]};
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule
`default_nettype wire

>>> test/tb.sv
`default_nettype none
module tb;
    import trbr_pkg::*;

    localparam int StallLimit = 2000;
    localparam int LongHold   = 300;
    localparam int SpareReg   = 1;
    localparam logic [ApbAddrW-1:0] AddrRingBase = ApbAddrW'(8 * int'(RegRingBase));
    localparam logic [ApbAddrW-1:0] AddrSpare    = ApbAddrW'(8 * SpareReg);

    typedef enum {RxFree, RxCoin, RxBeat} rx_mode_t;

    typedef struct packed {
        logic [63:0] param;
        logic [31:0] status;
        logic [15:0] upper;
        logic [5:0]  kind;
        logic [8:0]  flags;
        logic        cyc;
    } trb_slot_t;

    typedef struct {
        logic        valid;
        logic [63:0] param;
        logic [31:0] status;
        logic [5:0]  kind;
        logic [8:0]  flags;
        logic [15:0] upper;
        logic [63:0] caddr;
        logic [11:0] ppos;
        logic        pcyc;
    } ring_result_t;

    // mirror of the ring: store, both indices and cycle bits, plus the results owed
    class ring_mirror;
        trb_slot_t    ring [RingSlots];
        int           prod_idx;
        logic         prod_cyc;
        int           cons_idx;
        logic         cons_cyc;
        logic [63:0]  base;
        ring_result_t owed [$];
        int unsigned  errors;
        int unsigned  valid_deq;
        int unsigned  empty_deq;
        int unsigned  link_out;
        int unsigned  prod_wraps;
        int unsigned  cons_wraps;

        function new();
            foreach (ring[i]) ring[i] = '0;
            prod_idx   = 0;
            prod_cyc   = 1'b1;
            cons_idx   = 0;
            cons_cyc   = 1'b1;
            base       = '0;
            errors     = 0;
            valid_deq  = 0;
            empty_deq  = 0;
            link_out   = 0;
            prod_wraps = 0;
            cons_wraps = 0;
        endfunction

        function void set_base(logic [63:0] val);
            base = val;
        endfunction

        function int owed_count();
            return owed.size();
        endfunction

        function void accept_item(logic op, logic [63:0] prm, logic [31:0] st,
                                  logic [5:0] k, logic [8:0] fl, logic [15:0] up);
            ring_result_t r;
            trb_slot_t    e;
            r = '{default: '0};
            if (op == OpEnqueue) begin
                ring[prod_idx] = '{prm, st, up, k, fl, prod_cyc};
                if (prod_idx == RingSlots - 2) begin
                    ring[RingSlots-1] = '{base, 32'd0, 16'd0, 6'(LinkKind), 9'd1, prod_cyc};
                    prod_idx = 0;
                    prod_cyc = ~prod_cyc;
                    prod_wraps++;
                end else begin
                    prod_idx++;
                end
            end else begin
                e = ring[cons_idx];
                if (e.kind != 6'd0 && e.cyc == cons_cyc) begin
                    r.valid  = 1'b1;
                    r.param  = e.param;
                    r.status = e.status;
                    r.kind   = e.kind;
                    r.flags  = e.flags;
                    r.upper  = e.upper;
                    valid_deq++;
                    if (e.kind == 6'(LinkKind)) link_out++;
                    if (cons_idx == RingSlots - 1) begin
                        cons_idx = 0;
                        cons_cyc = ~cons_cyc;
                        cons_wraps++;
                    end else begin
                        cons_idx++;
                    end
                end else begin
                    empty_deq++;
                end
            end
            r.caddr = base + (64'(cons_idx) << 4);
            r.ppos  = 12'(prod_idx);
            r.pcyc  = prod_cyc;
            owed.push_back(r);
        endfunction

        function void cmp(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s: expected %h, got %h", name, want, got);
                errors++;
            end
        endfunction

        function void compare_result(logic [MDataW-1:0] d, logic [0:0] u);
            ring_result_t w;
            if (owed.size() == 0) begin
                $error("result item with nothing owed: %h / %h", d, u);
                errors++;
                return;
            end
            w = owed.pop_front();
            cmp("entry_valid", 64'(w.valid), 64'(u[0]));
            cmp("out_parameter", w.param, d[63:0]);
            cmp("out_status", 64'(w.status), 64'(d[95:64]));
            cmp("out_kind", 64'(w.kind), 64'(d[101:96]));
            cmp("out_flags", 64'(w.flags), 64'(d[110:102]));
            cmp("out_upper_control", 64'(w.upper), 64'(d[126:111]));
            cmp("consumer_address", w.caddr, d[190:127]);
            cmp("producer_position", 64'(w.ppos), 64'(d[202:191]));
            cmp("producer_cycle_out", 64'(w.pcyc), 64'(d[203]));
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [SDataW-1:0]    s_tdata  = '0;
    logic [0:0]           s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [MDataW-1:0]    m_tdata;
    logic [0:0]           m_tuser;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [ApbAddrW-1:0]  paddr    = '0;
    logic [ApbDataW-1:0]  pwdata   = '0;
    logic [ApbDataW-1:0]  prdata;
    logic                 pready;

    rx_mode_t   rx_mode    = RxFree;
    logic       rx_hold_go = 1'b0;
    int         rx_hold_left = 0;
    int         rx_beat      = 0;
    int         items_sent   = 0;
    int         base_writes  = 0;
    ring_mirror mirror;

    trb_ring_cycle_engine_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // result side: check, then pick next tready from the current stall pattern
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) mirror.compare_result(m_tdata, m_tuser);
        if (rx_hold_go) rx_hold_left = LongHold;
        rx_beat++;
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RxFree: m_tready <= 1'b1;
                RxCoin: m_tready <= ($urandom_range(0, 99) < 65);
                default: m_tready <= ((rx_beat % 5) != 2) && ((rx_beat % 11) < 8);
            endcase
        end
    end

    initial begin
        int stuck;
        stuck = 0;
        while (stuck < StallLimit) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stuck = 0;
            else stuck++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    task automatic push_item(input logic op, input logic [63:0] prm, input logic [31:0] st,
                             input logic [5:0] k, input logic [8:0] fl,
                             input logic [15:0] up);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, up, fl, k, st, prm};
        do @(posedge aclk); while (!s_tready);
        mirror.accept_item(op, prm, st, k, fl, up);
        items_sent++;
    endtask

    task automatic drain_ring();
        s_tvalid <= 1'b0;
        while (mirror.owed_count() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [ApbAddrW-1:0] addr, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == AddrRingBase) begin
            mirror.set_base(val);
            base_writes++;
        end
        @(posedge aclk);
    endtask

    task automatic read_back_base();
        logic [63:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= AddrRingBase;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== mirror.base) begin
            $error("ring_base_address readback: expected %h, got %h", mirror.base, got);
            mirror.errors++;
        end
        @(posedge aclk);
    endtask

    task automatic run_phase(input int n, input int enq_pct, input int max_gap);
        int   left;
        int   burst;
        int   gap;
        logic op;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && left > 0) begin
                op = ($urandom_range(0, 99) < enq_pct) ? OpEnqueue : OpDequeue;
                push_item(op, {$urandom, $urandom}, $urandom, 6'($urandom_range(1, 63)),
                          9'($urandom), 16'($urandom));
                burst--;
                left--;
            end
            gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    initial begin
        int          ph;
        logic [63:0] base_val;
        int          n_items [6] = '{560, 160, 160, 160, 160, 160};
        int          enq_pct [6] = '{97, 50, 35, 65, 45, 55};
        int          gap_max [6] = '{0, 6, 3, 0, 8, 2};
        rx_mode_t    modes   [6] = '{RxBeat, RxCoin, RxCoin, RxFree, RxFree, RxBeat};

        mirror = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // base at the top so the consumer address wraps on the first advance
        apb_write(AddrRingBase, 64'hFFFF_FFFF_FFFF_FFF0);
        apb_write(AddrSpare, {$urandom, $urandom});
        read_back_base();

        push_item(OpDequeue, '0, '0, '0, '0, '0);
        push_item(OpDequeue, '1, '1, '1, '1, '1);
        push_item(OpEnqueue, '1, '1, 6'h3F, 9'h1FF, 16'hFFFF);
        push_item(OpEnqueue, '0, '0, 6'd1, '0, '0);
        push_item(OpEnqueue, 64'hA5A5_5A5A_F00F_0FF0, 32'h5A5A_A5A5, 6'(LinkKind),
                  9'h155, 16'hAAAA);
        push_item(OpDequeue, '0, '0, '0, '0, '0);
        push_item(OpDequeue, '0, '0, '0, '0, '0);
        push_item(OpDequeue, '0, '0, '0, '0, '0);
        push_item(OpDequeue, '0, '0, '0, '0, '0);
        // empty-type block: the consumer stalls on it until the producer laps twice
        push_item(OpEnqueue, '1, '1, 6'd0, 9'h1FF, 16'hFFFF);
        push_item(OpDequeue, '0, '0, '0, '0, '0);
        push_item(OpDequeue, '1, '1, '1, '1, '1);
        push_item(OpEnqueue, 64'h1, 32'h1, 6'd5, 9'h1, 16'h1);
        push_item(OpDequeue, '0, '0, '0, '0, '0);
        drain_ring();

        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: base_val = '0;
                2: base_val = 64'hFFFF_FFFF_FFFF_FFF0;
                4: base_val = 64'h1;
                default: base_val = {$urandom, $urandom};
            endcase
            apb_write(AddrRingBase, base_val);
            if (ph == 1) apb_write(AddrSpare, '1);
            read_back_base();
            rx_mode <= modes[ph];
            if (ph == 2) begin
                rx_hold_go <= 1'b1;
                @(posedge aclk);
                rx_hold_go <= 1'b0;
            end
            run_phase(n_items[ph], enq_pct[ph], gap_max[ph]);
            drain_ring();
        end

        $display("Sent %0d items over %0d base settings: %0d owned dequeues, %0d refused",
                 items_sent, base_writes, mirror.valid_deq, mirror.empty_deq);
        $display("Producer wrapped %0d times, consumer %0d times, %0d link-type entries read",
                 mirror.prod_wraps, mirror.cons_wraps, mirror.link_out);
        if (mirror.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> filelist.f
rtl/trbr_pkg.sv
rtl/trbr_store.sv
rtl/trb_ring_cycle_engine_top.sv
test/tb.sv
